// ----- rtl/core/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// No dependencies; imported by dq_store and double_ended_queue.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH        = 64;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int HANDLE_W     = 32;
    localparam int REQ_TYPE_W   = 3;
    localparam int STATUS_W     = 2;
    localparam int ITEM_COUNT_W = 7;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_CLEAR      = 3'd4,
        REQ_QUERY      = 3'd5
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [HANDLE_W-1:0]   item_value;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [HANDLE_W-1:0]     front_value;
        logic [HANDLE_W-1:0]     back_value;
        logic [ITEM_COUNT_W-1:0] item_count;
    } out_beat_t;

    // Access bundle from the controller to the entry store.
    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [HANDLE_W-1:0] wr_data;
        logic                rd_en;
        logic [PTR_W-1:0]    front_addr;
        logic [PTR_W-1:0]    back_addr;
    } store_req_t;

endpackage

// ----- rtl/core/dq_store.sv -----
// Entry store: one write port, two registered read ports.
// Depends on dq_pkg. Same-cycle write/read of one entry forwards the new data.
`timescale 1ns / 1ps

module dq_store (
    input  logic                      clk,
    input  dq_pkg::store_req_t        acc,
    output logic [dq_pkg::HANDLE_W-1:0] front_data,
    output logic [dq_pkg::HANDLE_W-1:0] back_data
);
    import dq_pkg::*;

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] front_reg;
    logic [HANDLE_W-1:0] back_reg;

    always_ff @(posedge clk)
    begin
        if (acc.wr_en)
        begin
            mem[acc.wr_addr] <= acc.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.rd_en)
        begin
            if (acc.wr_en && (acc.wr_addr == acc.front_addr))
            begin
                front_reg <= acc.wr_data;
            end
            else
            begin
                front_reg <= mem[acc.front_addr];
            end
            if (acc.wr_en && (acc.wr_addr == acc.back_addr))
            begin
                back_reg <= acc.wr_data;
            end
            else
            begin
                back_reg <= mem[acc.back_addr];
            end
        end
    end

    assign front_data = front_reg;
    assign back_data  = back_reg;

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// Bounded double-ended queue of 32-bit handles held in a ring memory.
// A request beat passes through the entry store's read registers (one memory read), then the response register.
// req_stall holds off the next request until its response, built from the store read, enters the output slot.
// Reset: head pointer and count clear to zero, no beats pending; entry store
// contents are not cleared. Depends on dq_pkg and dq_store.
`timescale 1ns / 1ps

module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dq_pkg::in_beat_t  req_beat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dq_pkg::out_beat_t rsp_beat
);
    import dq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // IDLE takes a request beat; READ waits for store data and an open output slot.
    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_code_t          status_reg, status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    out_beat_t             rsp_beat_reg, rsp_beat_next;

    store_req_t            acc;
    logic [HANDLE_W-1:0]   front_data;
    logic [HANDLE_W-1:0]   back_data;

    // Fold a sum below 2*DEPTH back into the ring.
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            r = s;
            if (s >= SUM_W'(DEPTH))
            begin
                r = s - SUM_W'(DEPTH);
            end
            return r[PTR_W-1:0];
        end
    endfunction

    dq_store u_store (
        .clk        (clk),
        .acc        (acc),
        .front_data (front_data),
        .back_data  (back_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_beat_next  = rsp_beat_reg;
        acc            = '0;

        // Output slot drains when the consumer takes the beat.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    case (req_code_t'(req_beat.req_type))
                        REQ_PUSH_FRONT:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                head_next   = (head_reg == '0) ? PTR_W'(DEPTH - 1)
                                                               : head_reg - PTR_W'(1);
                                acc.wr_en   = 1'b1;
                                acc.wr_addr = head_next;
                                acc.wr_data = req_beat.item_value;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                acc.wr_en   = 1'b1;
                                acc.wr_addr = ring_wrap(SUM_W'(head_reg) + SUM_W'(count_reg));
                                acc.wr_data = req_beat.item_value;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = ring_wrap(SUM_W'(head_reg) + SUM_W'(1));
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // query and unused codes leave the ring alone
                        end
                    endcase

                    // Fetch the new ends; the back address is junk when empty
                    // and the response masks it to zero.
                    acc.rd_en      = 1'b1;
                    acc.front_addr = head_next;
                    acc.back_addr  = ring_wrap(SUM_W'(head_next) + SUM_W'(count_next)
                                               - SUM_W'(1));
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_beat_next.status      = status_reg;
                    rsp_beat_next.item_count  = ITEM_COUNT_W'(count_reg);
                    rsp_beat_next.front_value = (count_reg == '0) ? '0 : front_data;
                    rsp_beat_next.back_value  = (count_reg == '0) ? '0 : back_data;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload: no reset needed.
    always_ff @(posedge clk)
    begin
        rsp_beat_reg <= rsp_beat_next;
    end

endmodule
